>>> rtl/jrct_pkg.sv
// Shared types and constants for the job ring completion tracker.
`timescale 1ns / 1ps

package jrct_pkg;

  localparam int ADDR_W    = 32;
  localparam int STATUS_W  = 32;
  localparam int SLOT_W    = 4;
  localparam int RETIRED_W = 5;

  // Result codes
  typedef enum logic [1:0] {
    CODE_ACCEPTED  = 2'd0,
    CODE_BUSY      = 2'd1,
    CODE_COMPLETED = 2'd2,
    CODE_NOT_FOUND = 2'd3
  } code_t;

  // Operation selector on the input side
  typedef enum logic {
    OP_ENQUEUE  = 1'b0,
    OP_COMPLETE = 1'b1
  } op_t;

  // One result beat as it leaves the sequencer
  typedef struct packed {
    code_t                 code;
    logic [SLOT_W-1:0]     slot;
    logic [STATUS_W-1:0]   status_out;
    logic [RETIRED_W-1:0]  retired_count;
  } result_t;

endpackage

>>> rtl/jrct_ram.sv
// Slot address memory: one write port, one registered read port.
`timescale 1ns / 1ps

module jrct_ram #(
  parameter int RING_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(RING_DEPTH)-1:0]     wr_addr,
  input  logic [jrct_pkg::ADDR_W-1:0]       wr_data,
  input  logic [$clog2(RING_DEPTH)-1:0]     rd_addr,
  output logic [jrct_pkg::ADDR_W-1:0]       rd_data
);
  import jrct_pkg::*;

  logic [ADDR_W-1:0] mem [RING_DEPTH];

  // Write, then read through a registered output
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/jrct_seq.sv
// Ring sequencer: enqueue, slot search, tail retire walk over the slot memory.
`timescale 1ns / 1ps

module jrct_seq #(
  parameter int RING_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [jrct_pkg::ADDR_W-1:0]       in_addr,
  input  logic [jrct_pkg::STATUS_W-1:0]     in_status,
  input  logic                              in_room,
  output logic                              res_valid,
  input  logic                              res_ready,
  output jrct_pkg::result_t                 res,
  output logic                              wr_en,
  output logic [$clog2(RING_DEPTH)-1:0]     wr_addr,
  output logic [jrct_pkg::ADDR_W-1:0]       wr_data,
  output logic [$clog2(RING_DEPTH)-1:0]     rd_addr,
  input  logic [jrct_pkg::ADDR_W-1:0]       rd_data
);
  import jrct_pkg::*;

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WALK,
    ST_DONE
  } state_t;

  state_t               state;
  logic [IDX_W-1:0]     head;
  logic [IDX_W-1:0]     tail;
  logic [IDX_W-1:0]     cur;
  logic [IDX_W-1:0]     rem;
  logic [IDX_W-1:0]     nt;
  logic [IDX_W-1:0]     retired;
  logic [ADDR_W-1:0]    addr_r;
  logic [STATUS_W-1:0]  status_r;

  logic [IDX_W-1:0]     space;
  logic                 enq_ok;
  logic                 hit;

  assign space     = tail - head - IDX_ONE;
  assign enq_ok    = in_room && (space != '0);
  assign hit       = (rd_data == addr_r);
  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  // Memory port steering: store on enqueue, zero on a match
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = '0;
    rd_addr = tail;
    case (state)
      ST_IDLE: begin
        wr_en   = in_valid && (in_op == OP_ENQUEUE) && enq_ok;
        wr_addr = head;
        wr_data = in_addr;
        rd_addr = tail;
      end
      ST_SEARCH: begin
        wr_en   = hit;
        wr_addr = cur;
        rd_addr = cur + IDX_ONE;
      end
      ST_WALK: begin
        rd_addr = nt + IDX_ONE;
      end
      default: begin
        rd_addr = tail;
      end
    endcase
  end

  // Sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            addr_r   <= in_addr;
            status_r <= in_status;
            if (in_op == OP_ENQUEUE) begin
              res.status_out    <= '0;
              res.retired_count <= '0;
              if (enq_ok) begin
                res.code <= CODE_ACCEPTED;
                res.slot <= SLOT_W'(head);
                head     <= head + IDX_ONE;
              end else begin
                res.code <= CODE_BUSY;
                res.slot <= '0;
              end
              state <= ST_DONE;
            end else if (head == tail) begin
              res.code          <= CODE_NOT_FOUND;
              res.slot          <= '0;
              res.status_out    <= '0;
              res.retired_count <= '0;
              state             <= ST_DONE;
            end else begin
              cur   <= tail;
              rem   <= head - tail;
              state <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (hit) begin
            res.code       <= CODE_COMPLETED;
            res.slot       <= SLOT_W'(cur);
            res.status_out <= status_r;
            if (cur == tail) begin
              nt      <= cur + IDX_ONE;
              retired <= IDX_ONE;
              state   <= ST_WALK;
            end else begin
              res.retired_count <= '0;
              state             <= ST_DONE;
            end
          end else if (rem == IDX_ONE) begin
            res.code          <= CODE_NOT_FOUND;
            res.slot          <= '0;
            res.status_out    <= '0;
            res.retired_count <= '0;
            state             <= ST_DONE;
          end else begin
            cur <= cur + IDX_ONE;
            rem <= rem - IDX_ONE;
          end
        end
        ST_WALK: begin
          // skip consecutive done slots still inside the pending range
          if ((nt != head) && (rd_data == '0)) begin
            nt      <= nt + IDX_ONE;
            retired <= retired + IDX_ONE;
          end else begin
            tail              <= nt;
            res.retired_count <= RETIRED_W'(retired);
            state             <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_same_slot_rw: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH && wr_en) |-> (rd_addr != wr_addr))
    else $error("search writes and reads the same slot");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != ST_IDLE))
    else $error("accepted beat did not start work");

  a_head_only_on_enqueue: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_ready && (in_op == OP_ENQUEUE)) |=> $stable(head))
    else $error("head moved without an enqueue");

  a_tail_only_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state != ST_WALK) |=> $stable(tail))
    else $error("tail moved outside the retire walk");

endmodule

>>> rtl/job_ring_completion_tracker_top.sv
// Top level of the job ring completion tracker: sequencer, slot memory, output register.
//
//   channel  dir  tuser           tdata
//   s_*      in   op              job_address, job_status, ring_has_room
//   m_*      out  code            slot, status_out, retired_count
//
// An enqueue or an empty-ring completion goes from accept straight to its result.
// A completion searches pending slots from tail (one memory read per cycle) and,
// when it retires at tail, walks on over the done slots behind it.
// One item is in work at a time.
// Synchronous reset empties the ring at once; no memory sweep is needed.
// A stalled result holds the sequencer in its done state, so the next item waits.
`timescale 1ns / 1ps

module job_ring_completion_tracker_top #(
  parameter int RING_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // job_address[31:0], job_status[63:32], ring_has_room[64]
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // slot[3:0], status_out[35:4], retired_count[40:36]
  output logic [1:0]  m_tuser    // code
);
  import jrct_pkg::*;

  localparam int IDX_W = $clog2(RING_DEPTH);

  logic               res_valid;
  logic               res_ready;
  result_t            res;
  result_t            out_q;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]  wr_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]  rd_data;

  jrct_seq #(
    .RING_DEPTH (RING_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_addr   (s_tdata[31:0]),
    .in_status (s_tdata[63:32]),
    .in_room   (s_tdata[64]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  jrct_ram #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register: load when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_tuser = out_q.code;
  assign m_tdata = {7'd0, out_q.retired_count, out_q.status_out, out_q.slot};

endmodule

>>> bench/ring_tracker_checker.sv
// Checker for the job ring completion tracker: ring shadow, reply prediction, beat comparison.
`timescale 1ns / 1ps

module ring_tracker_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,   // job_address[31:0], job_status[63:32], ring_has_room[64]
  input  logic        s_tuser,   // op
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // slot[3:0], status_out[35:4], retired_count[40:36]
  input  logic [1:0]  m_tuser,   // code
  output int          failures,
  output int          owed_count,
  output int          replies_seen
);

  import jrct_pkg::*;

  localparam int SLOTS = 2 ** SLOT_W;

  // Shadow of the ring: addresses per slot, fill and retire pointers
  logic [ADDR_W-1:0] ring_addr [SLOTS];
  logic [SLOT_W-1:0] fill_ptr;
  logic [SLOT_W-1:0] retire_ptr;

  // Replies predicted but not yet seen on the output
  result_t owed_replies [$];
  int      miss_total;

  // Apply one job beat to the shadow and work out the reply it earns
  function automatic result_t predict_reply(op_t op, logic [ADDR_W-1:0] addr,
                                            logic [STATUS_W-1:0] status, logic room);
    result_t            r;
    logic [SLOT_W-1:0]  span;
    logic [SLOT_W-1:0]  scan;
    logic [SLOT_W-1:0]  hit;
    logic [SLOT_W-1:0]  nt;
    logic [RETIRED_W-1:0] retired;
    logic               found;
    int                 i;
    r = '0;
    if (op == OP_ENQUEUE) begin
      // one slot always stays empty, so a full ring has zero space
      span = retire_ptr - fill_ptr - 1'b1;
      if (!room || span == '0) begin
        r.code = CODE_BUSY;
      end else begin
        ring_addr[fill_ptr] = addr;
        r.code = CODE_ACCEPTED;
        r.slot = fill_ptr;
        fill_ptr = fill_ptr + 1'b1;
      end
    end else begin
      // search pending slots from the oldest toward the newest
      span  = fill_ptr - retire_ptr;
      scan  = retire_ptr;
      hit   = '0;
      found = 1'b0;
      for (i = 0; i < span; i++) begin
        if (!found && ring_addr[scan] == addr) begin
          found = 1'b1;
          hit   = scan;
        end
        scan = scan + 1'b1;
      end
      if (!found) begin
        r.code = CODE_NOT_FOUND;
      end else begin
        ring_addr[hit] = '0;
        r.code       = CODE_COMPLETED;
        r.slot       = hit;
        r.status_out = status;
        // a hit at the oldest slot retires it and every done slot behind it
        if (hit == retire_ptr) begin
          nt      = retire_ptr;
          retired = '0;
          do begin
            nt      = nt + 1'b1;
            retired = retired + 1'b1;
            span    = fill_ptr - nt;
          end while (span != '0 && ring_addr[nt] == '0);
          retire_ptr      = nt;
          r.retired_count = retired;
        end
      end
    end
    return r;
  endfunction

  // Compare result beats first, then book the job beat of the same edge
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int k = 0; k < SLOTS; k++) ring_addr[k] = 32'd1;
      fill_ptr   = '0;
      retire_ptr = '0;
      owed_replies.delete();
      miss_total = 0;
      failures     <= 0;
      owed_count   <= 0;
      replies_seen <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        replies_seen <= replies_seen + 1;
        if (owed_replies.size() == 0) begin
          miss_total++;
          if (miss_total <= 10)
            $display("%0t: reply beat with none owed: code %0d tdata %h",
                     $realtime, m_tuser, m_tdata);
        end else begin
          want = owed_replies.pop_front();
          if (m_tuser !== want.code || m_tdata[3:0] !== want.slot ||
              m_tdata[35:4] !== want.status_out || m_tdata[40:36] !== want.retired_count) begin
            miss_total++;
            // each pair is expected/actual
            if (miss_total <= 10)
              $display("%0t: mismatch code %0d/%0d slot %0d/%0d status %h/%h retired %0d/%0d",
                       $realtime, want.code, m_tuser, want.slot, m_tdata[3:0],
                       want.status_out, m_tdata[35:4], want.retired_count, m_tdata[40:36]);
          end
        end
      end
      if (s_tvalid && s_tready)
        owed_replies.push_back(predict_reply(op_t'(s_tuser), s_tdata[31:0],
                                             s_tdata[63:32], s_tdata[64]));
      failures   <= miss_total;
      owed_count <= owed_replies.size();
    end
  end

endmodule

>>> bench/tb.sv
// Testbench top for the job ring completion tracker: clock, reset, job beats, verdict.
`timescale 1ns / 1ps

module tb;

  import jrct_pkg::*;

  localparam int GAP_MAX      = 13;
  localparam int WATCH_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_JOBS  = 1800;
  localparam int POOL_MAX     = 48;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [71:0] s_tdata  = '0;
  logic        s_tuser  = OP_ENQUEUE;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [47:0] m_tdata;
  wire  [1:0]  m_tuser;

  int failures;
  int owed_count;
  int replies_seen;
  int quiet_cycles;
  int enq_sent;
  int done_sent;
  int drain_pauses;
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;

  // Addresses handed out on enqueue, drawn from for completions
  logic [ADDR_W-1:0] job_pool [$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  job_ring_completion_tracker_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  ring_tracker_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .failures     (failures),
    .owed_count   (owed_count),
    .replies_seen (replies_seen)
  );

  // Present one job beat after a random gap and hold it until taken
  task automatic send_job(input op_t op, input logic [ADDR_W-1:0] addr,
                          input logic [STATUS_W-1:0] status, input logic room);
    int gap;
    gap = sender_idles ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, room, status, addr};
    do @(posedge clk); while (!s_tready);
    if (op == OP_ENQUEUE) begin
      enq_sent++;
      if (room) job_pool.push_back(addr);
      if (job_pool.size() > POOL_MAX) void'(job_pool.pop_front());
    end else begin
      done_sent++;
    end
  endtask

  // Drop valid and hold off until every owed reply has come back
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    drain_pauses++;
  endtask

  // Reply side: random stalls, with stretches of steady ready
  initial begin
    int stall;
    forever begin
      stall = receiver_idles ? $urandom_range(0, GAP_MAX) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if ($urandom_range(0, 39) == 0) receiver_idles = !receiver_idles;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCH_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Job stimulus
  initial begin
    logic [ADDR_W-1:0] addr;
    int mode;
    int chunk;
    int enq_pct;
    int pick;
    int idx;
    int k;
    int sent_random;
    enq_sent     = 0;
    done_sent    = 0;
    drain_pauses = 0;
    sent_random  = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty ring: reset contents must not match
    send_job(OP_COMPLETE, 32'd1, 32'h1234_5678, 1'b1);
    // engine without room refuses
    send_job(OP_ENQUEUE, 32'hDEAD_BEEF, 32'h0, 1'b0);
    send_job(OP_ENQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // zero address lands already marked done
    send_job(OP_ENQUEUE, 32'h0, 32'h0, 1'b1);
    send_job(OP_ENQUEUE, 32'h1, 32'h0, 1'b1);
    // out of order, then at the tail with a skip over done slots
    send_job(OP_COMPLETE, 32'h1, 32'hA5A5_5A5A, 1'b0);
    send_job(OP_COMPLETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_job(OP_COMPLETE, 32'h0, 32'h0, 1'b1);
    // fill past the wrap until the ring reports full
    for (k = 0; k < 16; k++) send_job(OP_ENQUEUE, 32'h1000_0000 + k, $urandom, 1'b1);
    send_job(OP_COMPLETE, 32'h1000_0002, 32'h0F0F_F0F0, 1'b1);
    // zero address hits the slot just marked done
    send_job(OP_COMPLETE, 32'h0, 32'h5555_AAAA, 1'b1);
    send_job(OP_COMPLETE, 32'h1000_0000, 32'h0, 1'b1);
    send_job(OP_COMPLETE, 32'h1000_0001, 32'h8000_0001, 1'b1);
    wait_for_drain();

    // Random chunks leaning toward fill, drain or an even mix
    while (sent_random < RANDOM_JOBS) begin
      mode         = $urandom_range(0, 2);
      chunk        = $urandom_range(30, 80);
      sender_idles = ($urandom_range(0, 3) != 0);
      enq_pct      = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
      for (k = 0; k < chunk && sent_random < RANDOM_JOBS; k++) begin
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < enq_pct) begin
          if (pick < 5)       addr = '0;
          else if (pick < 15) addr = $urandom_range(1, 4);
          else                addr = $urandom;
          send_job(OP_ENQUEUE, addr, $urandom, $urandom_range(0, 9) != 0);
        end else begin
          if (pick < 80 && job_pool.size() > 0) begin
            idx  = $urandom_range(0, job_pool.size() - 1);
            addr = job_pool[idx];
            job_pool.delete(idx);
          end else if (pick < 88) begin
            addr = '0;
          end else if (pick < 94) begin
            addr = $urandom_range(1, 4);
          end else begin
            addr = $urandom;
          end
          send_job(OP_COMPLETE, addr, $urandom, 1'($urandom_range(0, 1)));
        end
        sent_random++;
        if (sent_random % 300 == 0) wait_for_drain();
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d enqueues and %0d completions, %0d replies checked, %0d drain pauses",
             enq_sent, done_sent, replies_seen, drain_pauses);
    if (failures == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d reply beats failed", failures);
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/jrct_pkg.sv
rtl/jrct_ram.sv
rtl/jrct_seq.sv
rtl/job_ring_completion_tracker_top.sv
bench/ring_tracker_checker.sv
bench/tb.sv
